>>> hw/rtl/circumcircle_from_three_points_top_defines.svh
// assertion macros for the circumcircle block
// clocked on clk_i, reset by rst_ni in the module that uses them
`ifndef CIRCUMCIRCLE_FROM_THREE_POINTS_TOP_DEFINES_SVH
`define CIRCUMCIRCLE_FROM_THREE_POINTS_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CC_ASSERT(lbl, prop, msg)
`define CC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/ccirc_pkg.sv
// shared types for the circumcircle block: input and result words, sign flags
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ccirc_pkg;

  localparam int unsigned FieldWidth = 32;

  typedef struct packed {
    logic signed [FieldWidth-1:0] first_x;
    logic signed [FieldWidth-1:0] first_y;
    logic signed [FieldWidth-1:0] second_x;
    logic signed [FieldWidth-1:0] second_y;
    logic signed [FieldWidth-1:0] third_x;
    logic signed [FieldWidth-1:0] third_y;
  } ccirc_in_t;

  typedef struct packed {
    logic signed [FieldWidth-1:0] center_x;
    logic signed [FieldWidth-1:0] center_y;
    logic [FieldWidth-1:0]        circle_radius;
    logic                         degenerate;
    logic                         saturated;
  } ccirc_out_t;

  // quotient signs and zero-divisor flag from the determinant front end
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic degen;
  } ccirc_sign_t;

endpackage

`default_nettype wire

>>> hw/rtl/ccirc_front.sv
// six-stage front end: differences, squares, determinant and center numerators
// uses ccirc_pkg; feeds ccirc_div
`timescale 1ns / 1ps
`default_nettype none

module ccirc_front import ccirc_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  ccirc_in_t                     pts_i,
  output logic                          valid_o,
  output logic [3*COORD_WIDTH+2:0]      num_x_o,
  output logic [3*COORD_WIDTH+2:0]      num_y_o,
  output logic [2*COORD_WIDTH+2:0]      den_o,
  output ccirc_sign_t                   sign_o,
  output logic signed [COORD_WIDTH-1:0] x1_o,
  output logic signed [COORD_WIDTH-1:0] y1_o
);

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned DW   = W + 1;
  localparam int unsigned HW   = W + 1;
  localparam int unsigned QW   = 2 * W;
  localparam int unsigned PPW  = 2 * W + 2;
  localparam int unsigned FPW  = 3 * W + 2;
  localparam int unsigned NSW  = 3 * W + 4;
  localparam int unsigned DSW  = 2 * W + 3;
  localparam int unsigned NMW  = 3 * W + 1;
  localparam int unsigned DMW  = 2 * W + 2;
  localparam int unsigned NUMW = 3 * W + 3;
  localparam int unsigned DENW = 2 * W + 3;

  // stage 1
  logic signed [W-1:0]  px [3];
  logic signed [W-1:0]  py [3];
  logic signed [QW-1:0] xe [3];
  logic signed [QW-1:0] ye [3];
  logic signed [W-1:0]  x_s1_q [3];
  logic signed [W-1:0]  y1_s1_q;
  logic signed [DW-1:0] dx_s1_q [3];
  logic signed [DW-1:0] dy_s1_q [3];
  logic [QW-1:0]        xsq_s1_q [3];
  logic [QW-1:0]        ysq_s1_q [3];
  // stage 2
  logic [QW-1:0]         q_s2_q [3];
  logic signed [DSW-1:0] dp_s2_q [3];
  logic signed [DW-1:0]  dx_s2_q [3];
  logic signed [DW-1:0]  dy_s2_q [3];
  logic signed [W-1:0]   x1_s2_q, y1_s2_q;
  // stage 3
  logic signed [HW-1:0]  qlo [3];
  logic signed [HW-1:0]  qhi [3];
  logic signed [PPW-1:0] plx_s3_q [3];
  logic signed [PPW-1:0] phx_s3_q [3];
  logic signed [PPW-1:0] ply_s3_q [3];
  logic signed [PPW-1:0] phy_s3_q [3];
  logic signed [DSW-1:0] ds_s3_q;
  logic signed [W-1:0]   x1_s3_q, y1_s3_q;
  // stage 4
  logic signed [FPW-1:0] fx_s4_q [3];
  logic signed [FPW-1:0] fy_s4_q [3];
  logic signed [DSW-1:0] ds_s4_q;
  logic signed [W-1:0]   x1_s4_q, y1_s4_q;
  // stage 5
  logic signed [NSW-1:0] nx_s5_q, ny_s5_q;
  logic signed [DSW-1:0] ds_s5_q;
  logic signed [W-1:0]   x1_s5_q, y1_s5_q;
  // stage 6 logic
  logic signed [NSW-1:0] nxa, nya;
  logic signed [DSW-1:0] dsa;
  logic [DMW-1:0]        dm2;
  logic                  dzero;
  logic [NUMW-1:0]       num_x_d, num_y_d;
  logic [5:0]            vld_q;

  always_comb begin
    px[0] = $signed(pts_i.first_x[W-1:0]);
    px[1] = $signed(pts_i.second_x[W-1:0]);
    px[2] = $signed(pts_i.third_x[W-1:0]);
    py[0] = $signed(pts_i.first_y[W-1:0]);
    py[1] = $signed(pts_i.second_y[W-1:0]);
    py[2] = $signed(pts_i.third_y[W-1:0]);
    for (int k = 0; k < 3; k++) begin
      xe[k] = QW'(px[k]);
      ye[k] = QW'(py[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qlo[k] = $signed({1'b0, q_s2_q[k][W-1:0]});
      qhi[k] = $signed({1'b0, q_s2_q[k][QW-1:W]});
    end
  end

  always_comb begin
    nxa   = nx_s5_q[NSW-1] ? -nx_s5_q : nx_s5_q;
    nya   = ny_s5_q[NSW-1] ? -ny_s5_q : ny_s5_q;
    dsa   = ds_s5_q[DSW-1] ? -ds_s5_q : ds_s5_q;
    dzero = (ds_s5_q == '0);
    // zero divisor becomes one raw unit
    dm2   = dzero ? DMW'(1) : {dsa[DMW-2:0], 1'b0};
    num_x_d = NUMW'({nxa[NMW-1:0], 1'b0}) + NUMW'(dm2);
    num_y_d = NUMW'({nya[NMW-1:0], 1'b0}) + NUMW'(dm2);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: term k pairs point k with the opposite-side difference
      for (int k = 0; k < 3; k++) begin
        x_s1_q[k]   <= px[k];
        xsq_s1_q[k] <= $unsigned(QW'(xe[k] * xe[k]));
        ysq_s1_q[k] <= $unsigned(QW'(ye[k] * ye[k]));
      end
      y1_s1_q    <= py[0];
      dx_s1_q[0] <= DW'(px[1]) - DW'(px[2]);
      dx_s1_q[1] <= DW'(px[0]) - DW'(px[2]);
      dx_s1_q[2] <= DW'(px[0]) - DW'(px[1]);
      dy_s1_q[0] <= DW'(py[1]) - DW'(py[2]);
      dy_s1_q[1] <= DW'(py[0]) - DW'(py[2]);
      dy_s1_q[2] <= DW'(py[0]) - DW'(py[1]);
      // stage 2
      for (int k = 0; k < 3; k++) begin
        q_s2_q[k]  <= xsq_s1_q[k] + ysq_s1_q[k];
        dp_s2_q[k] <= DSW'(x_s1_q[k]) * DSW'(dy_s1_q[k]);
        dx_s2_q[k] <= dx_s1_q[k];
        dy_s2_q[k] <= dy_s1_q[k];
      end
      x1_s2_q <= x_s1_q[0];
      y1_s2_q <= y1_s1_q;
      // stage 3: squared norms split in halves for the numerator products
      for (int k = 0; k < 3; k++) begin
        plx_s3_q[k] <= PPW'(qlo[k]) * PPW'(dx_s2_q[k]);
        phx_s3_q[k] <= PPW'(qhi[k]) * PPW'(dx_s2_q[k]);
        ply_s3_q[k] <= PPW'(qlo[k]) * PPW'(dy_s2_q[k]);
        phy_s3_q[k] <= PPW'(qhi[k]) * PPW'(dy_s2_q[k]);
      end
      ds_s3_q <= dp_s2_q[0] - dp_s2_q[1] + dp_s2_q[2];
      x1_s3_q <= x1_s2_q;
      y1_s3_q <= y1_s2_q;
      // stage 4
      for (int k = 0; k < 3; k++) begin
        fx_s4_q[k] <= (FPW'(phx_s3_q[k]) <<< W) + FPW'(plx_s3_q[k]);
        fy_s4_q[k] <= (FPW'(phy_s3_q[k]) <<< W) + FPW'(ply_s3_q[k]);
      end
      ds_s4_q <= ds_s3_q;
      x1_s4_q <= x1_s3_q;
      y1_s4_q <= y1_s3_q;
      // stage 5
      nx_s5_q <= NSW'(fy_s4_q[0]) - NSW'(fy_s4_q[1]) + NSW'(fy_s4_q[2]);
      ny_s5_q <= NSW'(fx_s4_q[1]) - NSW'(fx_s4_q[0]) - NSW'(fx_s4_q[2]);
      ds_s5_q <= ds_s4_q;
      x1_s5_q <= x1_s4_q;
      y1_s5_q <= y1_s4_q;
      // stage 6
      num_x_o      <= num_x_d;
      num_y_o      <= num_y_d;
      den_o        <= {dm2, 1'b0};
      sign_o.neg_x <= nx_s5_q[NSW-1] ^ ds_s5_q[DSW-1];
      sign_o.neg_y <= ny_s5_q[NSW-1] ^ ds_s5_q[DSW-1];
      sign_o.degen <= dzero;
      x1_o         <= x1_s5_q;
      y1_o         <= y1_s5_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  assign valid_o = vld_q[5];

endmodule

`default_nettype wire

>>> hw/rtl/ccirc_div.sv
// two-lane pipelined restoring divider, one quotient bit per stage,
// truncating quotient with saturation; no package dependency
`timescale 1ns / 1ps
`default_nettype none

module ccirc_div #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned SIDE_W      = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [1:0][3*COORD_WIDTH+2:0]   num_i,
  input  logic [2*COORD_WIDTH+2:0]        den_i,
  input  logic [1:0]                      neg_i,
  input  logic [SIDE_W-1:0]               side_i,
  output logic                            valid_o,
  output logic [1:0][COORD_WIDTH-1:0]     quo_o,
  output logic [1:0]                      sat_o,
  output logic [SIDE_W-1:0]               side_o
);

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned NS   = W + 1;
  localparam int unsigned RW   = 3 * W + 4;
  localparam int unsigned QBW  = W + 1;
  localparam int unsigned DENW = 2 * W + 3;

  logic [1:0][RW-1:0]  rem_q [NS+1];
  logic [1:0][RW-1:0]  rem_d [NS+1];
  logic [1:0][QBW-1:0] quo_q [NS+1];
  logic [1:0][QBW-1:0] quo_d [NS+1];
  logic [1:0]          ovf_q [NS+1];
  logic [1:0]          neg_q [NS+1];
  logic [DENW-1:0]     den_q [NS+1];
  logic [SIDE_W-1:0]   side_q [NS+1];
  logic [1:0]          ovf_d;
  logic [1:0][W-1:0]   fin_d;
  logic [1:0]          fsat_d;
  logic [NS+1:0]       vld_q;

  always_comb begin
    logic [RW-1:0] trial;
    for (int l = 0; l < 2; l++) begin
      rem_d[0][l] = RW'(num_i[l]);
      quo_d[0][l] = '0;
      // quotient would not fit in the bits worked out below
      ovf_d[l]    = RW'(num_i[l]) >= (RW'(den_i) << NS);
    end
    for (int k = 1; k <= NS; k++) begin
      trial = RW'(den_q[k-1]) << (NS - k);
      for (int l = 0; l < 2; l++) begin
        rem_d[k][l] = rem_q[k-1][l];
        quo_d[k][l] = quo_q[k-1][l];
        if (rem_q[k-1][l] >= trial) begin
          rem_d[k][l]         = rem_q[k-1][l] - trial;
          quo_d[k][l][NS-k]   = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic [QBW-1:0] lim;
    logic [QBW-1:0] qs;
    for (int l = 0; l < 2; l++) begin
      lim = neg_q[NS][l] ? (QBW'(1) << (W - 1)) : ((QBW'(1) << (W - 1)) - QBW'(1));
      fsat_d[l] = ovf_q[NS][l] || (quo_q[NS][l] > lim);
      qs = fsat_d[l] ? lim : quo_q[NS][l];
      fin_d[l] = W'(neg_q[NS][l] ? (QBW'(0) - qs) : qs);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rem_d[0];
      quo_q[0]  <= quo_d[0];
      ovf_q[0]  <= ovf_d;
      neg_q[0]  <= neg_i;
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
      for (int k = 1; k <= NS; k++) begin
        rem_q[k]  <= rem_d[k];
        quo_q[k]  <= quo_d[k];
        ovf_q[k]  <= ovf_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        den_q[k]  <= den_q[k-1];
        side_q[k] <= side_q[k-1];
      end
      quo_o  <= fin_d;
      sat_o  <= fsat_d;
      side_o <= side_q[NS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS:0], valid_i};
    end
  end

  assign valid_o = vld_q[NS+1];

endmodule

`default_nettype wire

>>> hw/rtl/ccirc_sqrt.sv
// pipelined digit-by-digit integer square root, one root bit per stage
// no package dependency; remainder is passed on for rounding
`timescale 1ns / 1ps
`default_nettype none

module ccirc_sqrt #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned SIDE_W      = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [2*COORD_WIDTH:0]     rad_sq_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  output logic [COORD_WIDTH:0]       root_o,
  output logic [2*COORD_WIDTH+1:0]   rem_o,
  output logic [SIDE_W-1:0]          side_o
);

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned NS  = W + 1;
  localparam int unsigned TW  = 2 * W + 2;
  localparam int unsigned RTW = W + 1;

  logic [TW-1:0]     rem_q  [NS];
  logic [TW-1:0]     rem_d  [NS];
  logic [RTW-1:0]    root_q [NS];
  logic [RTW-1:0]    root_d [NS];
  logic [SIDE_W-1:0] side_q [NS];
  logic [NS-1:0]     vld_q;

  always_comb begin
    logic [TW-1:0]  src_rem;
    logic [RTW-1:0] src_root;
    logic [TW-1:0]  t;
    int             b;
    for (int k = 0; k < NS; k++) begin
      b = W - k;
      if (k == 0) begin
        src_rem  = TW'(rad_sq_i);
        src_root = '0;
      end else begin
        src_rem  = rem_q[k-1];
        src_root = root_q[k-1];
      end
      // (2r + 2^b) * 2^b with r holding only bits above b
      t = (TW'(src_root) << (b + 1)) | (TW'(1) << (2 * b));
      rem_d[k]  = src_rem;
      root_d[k] = src_root;
      if (src_rem >= t) begin
        rem_d[k]     = src_rem - t;
        root_d[k][b] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NS; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
      side_q[0] <= side_i;
      for (int k = 1; k < NS; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[NS-1];
  assign root_o  = root_q[NS-1];
  assign rem_o   = rem_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

`default_nettype wire

>>> hw/rtl/circumcircle_from_three_points_top.sv
// circumcircle of three points, fully pipelined.
// input word: three points, signed fixed point, low COORD_WIDTH bits of each
// field used. result word: center x/y (signed, rounded to nearest, saturated),
// radius (unsigned, rounded, saturated), degenerate and saturated flags.
// both channels are valid/ready; a word moves when valid and ready are high.
// between input accept and output valid lie six determinant stages,
// COORD_WIDTH+3 divider stages, three radius-prep stages, COORD_WIDTH+1
// square-root stages and the output register. one word is accepted every
// cycle while in_ready_o is high; the bit-per-stage divider and root
// pipelines set the depth.
// a two-entry output buffer (output register plus skid) lets the pipeline run
// on while a result waits; the pipeline freezes only when both are full, and
// in_ready_o drops for as long. reset empties every stage and the buffer.
// uses ccirc_pkg, ccirc_front, ccirc_div, ccirc_sqrt
`timescale 1ns / 1ps
`default_nettype none
`include "circumcircle_from_three_points_top_defines.svh"

module circumcircle_from_three_points_top import ccirc_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  ccirc_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ccirc_out_t out_data_o
);

  localparam int unsigned W     = COORD_WIDTH;
  localparam int unsigned NUMW  = 3 * W + 3;
  localparam int unsigned DENW  = 2 * W + 3;
  localparam int unsigned DSIDE = 2 * W + 1;
  localparam int unsigned SSIDE = 2 * W + 2;
  localparam int unsigned EW    = W + 1;
  localparam int unsigned SQW   = 2 * W;
  localparam int unsigned SQX   = 2 * W + 2;
  localparam int unsigned SW    = 2 * W + 1;
  localparam int unsigned TW    = 2 * W + 2;
  localparam int unsigned RUW   = W + 2;

  logic en;

  logic                  fr_valid;
  logic [NUMW-1:0]       fr_num_x, fr_num_y;
  logic [DENW-1:0]       fr_den;
  ccirc_sign_t           fr_sign;
  logic signed [W-1:0]   fr_x1, fr_y1;

  logic                  dv_valid;
  logic [1:0][W-1:0]     dv_quo;
  logic [1:0]            dv_sat;
  logic [DSIDE-1:0]      dv_side;
  logic signed [W-1:0]   dv_x1, dv_y1, dv_cx, dv_cy;
  logic                  dv_degen;

  logic                  r1_vld_q, r2_vld_q, r3_vld_q;
  logic signed [EW-1:0]  ex_r1_q, ey_r1_q;
  logic signed [SQX-1:0] exw, eyw;
  logic [SQW-1:0]        exsq_r2_q, eysq_r2_q;
  logic [SW-1:0]         rsq_r3_q;
  logic signed [W-1:0]   cx_r1_q, cy_r1_q, cx_r2_q, cy_r2_q, cx_r3_q, cy_r3_q;
  logic [1:0]            flg_r1_q, flg_r2_q, flg_r3_q;

  logic                  sq_valid;
  logic [W:0]            sq_root;
  logic [TW-1:0]         sq_rem;
  logic [SSIDE-1:0]      sq_side;
  logic signed [W-1:0]   sq_cx, sq_cy;
  logic                  sq_degen, sq_sat;
  logic [RUW-1:0]        root_up;
  logic                  rad_sat;
  logic [W-1:0]          radius;
  ccirc_out_t            pipe_word;

  logic                  out_valid_q, skid_valid_q;
  ccirc_out_t            out_q, skid_q;

  // pipeline advances unless the skid entry is taken
  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  ccirc_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .pts_i   (in_data_i),
    .valid_o (fr_valid),
    .num_x_o (fr_num_x),
    .num_y_o (fr_num_y),
    .den_o   (fr_den),
    .sign_o  (fr_sign),
    .x1_o    (fr_x1),
    .y1_o    (fr_y1)
  );

  ccirc_div #(
    .COORD_WIDTH (COORD_WIDTH),
    .SIDE_W      (DSIDE)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .num_i   ({fr_num_y, fr_num_x}),
    .den_i   (fr_den),
    .neg_i   ({fr_sign.neg_y, fr_sign.neg_x}),
    .side_i  ({fr_x1, fr_y1, fr_sign.degen}),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .sat_o   (dv_sat),
    .side_o  (dv_side)
  );

  assign dv_cx    = $signed(dv_quo[0]);
  assign dv_cy    = $signed(dv_quo[1]);
  assign dv_x1    = $signed(dv_side[DSIDE-1 -: W]);
  assign dv_y1    = $signed(dv_side[W:1]);
  assign dv_degen = dv_side[0];

  // radius uses the center as delivered, after clipping
  assign exw = SQX'(ex_r1_q);
  assign eyw = SQX'(ey_r1_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ex_r1_q   <= EW'(dv_x1) - EW'(dv_cx);
      ey_r1_q   <= EW'(dv_y1) - EW'(dv_cy);
      cx_r1_q   <= dv_cx;
      cy_r1_q   <= dv_cy;
      flg_r1_q  <= {dv_degen, |dv_sat};
      exsq_r2_q <= $unsigned(SQW'(exw * exw));
      eysq_r2_q <= $unsigned(SQW'(eyw * eyw));
      cx_r2_q   <= cx_r1_q;
      cy_r2_q   <= cy_r1_q;
      flg_r2_q  <= flg_r1_q;
      rsq_r3_q  <= SW'(exsq_r2_q) + SW'(eysq_r2_q);
      cx_r3_q   <= cx_r2_q;
      cy_r3_q   <= cy_r2_q;
      flg_r3_q  <= flg_r2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_vld_q <= 1'b0;
      r2_vld_q <= 1'b0;
      r3_vld_q <= 1'b0;
    end else if (en) begin
      r1_vld_q <= dv_valid;
      r2_vld_q <= r1_vld_q;
      r3_vld_q <= r2_vld_q;
    end
  end

  ccirc_sqrt #(
    .COORD_WIDTH (COORD_WIDTH),
    .SIDE_W      (SSIDE)
  ) u_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (r3_vld_q),
    .rad_sq_i (rsq_r3_q),
    .side_i   ({cx_r3_q, cy_r3_q, flg_r3_q}),
    .valid_o  (sq_valid),
    .root_o   (sq_root),
    .rem_o    (sq_rem),
    .side_o   (sq_side)
  );

  assign sq_cx    = $signed(sq_side[SSIDE-1 -: W]);
  assign sq_cy    = $signed(sq_side[W+1:2]);
  assign sq_degen = sq_side[1];
  assign sq_sat   = sq_side[0];

  always_comb begin
    // round up when the remainder exceeds the root
    root_up = (sq_rem > TW'(sq_root)) ? (RUW'(sq_root) + RUW'(1)) : RUW'(sq_root);
    rad_sat = (root_up[RUW-1:W] != '0);
    radius  = rad_sat ? '1 : root_up[W-1:0];
    pipe_word.center_x      = FieldWidth'(sq_cx);
    pipe_word.center_y      = FieldWidth'(sq_cy);
    pipe_word.circle_radius = FieldWidth'(radius);
    pipe_word.degenerate    = sq_degen;
    pipe_word.saturated     = sq_sat | rad_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_ready_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= sq_valid;
    end else if (sq_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_ready_i) begin
      out_q <= pipe_word;
    end else if (sq_valid) begin
      skid_q <= pipe_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CC_ASSERT(a_skid_needs_out, skid_valid_q |-> out_valid_q, "skid word without output word")
  `CC_ASSERT(a_skid_holds, skid_valid_q && !out_ready_i |=> skid_valid_q && $stable(skid_q), "skid word lost under stall")
  `CC_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_q && !skid_valid_q, "output buffer not empty after reset")

endmodule

`default_nettype wire

>>> tb/ccirc_checker.sv
// result checker for the circumcircle block: predicts each result word from
// the accepted input word and compares it with the block's output
// uses ccirc_pkg
`timescale 1ns / 1ps

module ccirc_checker import ccirc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  ccirc_in_t  in_data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  ccirc_out_t out_data_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef logic signed [159:0] wide_t;

  ccirc_out_t circle_q[$];
  int fails;

  // rounded quotient, ties away from zero, clipped to the signed 32-bit range
  function automatic wide_t round_quot(wide_t n, wide_t d, ref logic sat);
    wide_t an, ad, qq, lim;
    logic  neg;
    an  = (n < 0) ? -n : n;
    ad  = (d < 0) ? -d : d;
    neg = (n < 0) != (d < 0);
    qq  = (2 * an + ad) / (2 * ad);
    lim = neg ? (wide_t'(1) <<< 31) : ((wide_t'(1) <<< 31) - 1);
    if (qq > lim) begin
      sat = 1'b1;
      qq  = lim;
    end
    return neg ? -qq : qq;
  endfunction

  function automatic ccirc_out_t predict_circle(ccirc_in_t p);
    wide_t x1, y1, x2, y2, x3, y3, q1, q2, q3;
    wide_t d, nx, ny, cx, cy, ex, ey, dsq, r, c, rmax;
    logic  sat, degen;
    ccirc_out_t res;
    x1 = p.first_x;  y1 = p.first_y;
    x2 = p.second_x; y2 = p.second_y;
    x3 = p.third_x;  y3 = p.third_y;
    sat = 1'b0;
    degen = 1'b0;
    q1 = x1 * x1 + y1 * y1;
    q2 = x2 * x2 + y2 * y2;
    q3 = x3 * x3 + y3 * y3;
    d  = 2 * (x1 * (y2 - y3) - x2 * (y1 - y3) + x3 * (y1 - y2));
    nx = q1 * (y2 - y3) - q2 * (y1 - y3) + q3 * (y1 - y2);
    ny = -(q1 * (x2 - x3) - q2 * (x1 - x3) + q3 * (x1 - x2));
    // collinear points: smallest positive divisor
    if (d == 0) begin
      degen = 1'b1;
      d = 1;
    end
    cx = round_quot(nx, d, sat);
    cy = round_quot(ny, d, sat);
    ex = x1 - cx;
    ey = y1 - cy;
    dsq = ex * ex + ey * ey;
    r = 0;
    for (int b = 40; b >= 0; b--) begin
      c = r | (wide_t'(1) <<< b);
      if (c * c <= dsq) r = c;
    end
    if (dsq - r * r > r) r = r + 1;
    rmax = (wide_t'(1) <<< 32) - 1;
    if (r > rmax) begin
      r = rmax;
      sat = 1'b1;
    end
    res.center_x      = cx[31:0];
    res.center_y      = cy[31:0];
    res.circle_radius = r[31:0];
    res.degenerate    = degen;
    res.saturated     = sat;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ccirc_out_t want;
    if (!rst_ni) begin
      circle_q.delete();
      fails = 0;
    end else begin
      if (in_valid_i && in_ready_i) circle_q.push_back(predict_circle(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (circle_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result word %h", out_data_i);
        end else begin
          want = circle_q.pop_front();
          if (want.center_x !== out_data_i.center_x ||
              want.center_y !== out_data_i.center_y ||
              want.circle_radius !== out_data_i.circle_radius ||
              want.degenerate !== out_data_i.degenerate ||
              want.saturated !== out_data_i.saturated) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: cx %h/%h cy %h/%h r %h/%h dg %b/%b sat %b/%b (exp/act)",
                       want.center_x, out_data_i.center_x,
                       want.center_y, out_data_i.center_y,
                       want.circle_radius, out_data_i.circle_radius,
                       want.degenerate, out_data_i.degenerate,
                       want.saturated, out_data_i.saturated);
          end
        end
      end
    end
  end

  assign fail_count_o = fails;
  assign pending_o    = circle_q.size();

endmodule

>>> tb/tb_top.sv
// testbench top for the circumcircle block: clock, reset, point stimulus,
// output stalls and verdict; checking is done by ccirc_checker
`timescale 1ns / 1ps

module tb_top;
  import ccirc_pkg::*;

  localparam int NumRandom = 1830;
  localparam int IdleLimit = 4000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  ccirc_in_t  in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  ccirc_out_t out_data_o;
  int         fail_count, pending;
  logic       hold_req = 1'b0;
  int         idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  circumcircle_from_three_points_top uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  ccirc_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: stall modes change every so often, one long hold-off on request
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (600) @(posedge clk_i);
        hold_req <= 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 1) == 1);
        2: out_ready_i <= ($urandom_range(0, 4) == 0);
        default: out_ready_i <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  int burst_left = 0;

  task automatic send_points(ccirc_in_t p);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [31:0] rand_coord(int kind);
    logic [31:0] v;
    v = $urandom;
    case (kind)
      0: return v;
      1: return {{12{v[19]}}, v[19:0]};
      2: return {{20{v[11]}}, v[11:0]};
      default: return {{6{v[25]}}, v[25:0]};
    endcase
  endfunction

  function automatic ccirc_in_t pts(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                    logic [31:0] d, logic [31:0] e, logic [31:0] f);
    ccirc_in_t p;
    p = {a, b, c, d, e, f};
    return p;
  endfunction

  initial begin
    ccirc_in_t p;
    int kind, k;
    logic [31:0] mx, mn, one;
    mx = 32'h7fff_ffff;
    mn = 32'h8000_0000;
    one = 32'h0001_0000;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: coincident, collinear, plain triangles, extremes
    send_points(pts(0, 0, 0, 0, 0, 0));
    send_points(pts(one, one, one, one, one, one));
    send_points(pts(0, 0, one, one, 2 * one, 2 * one));
    send_points(pts(0, 0, one, 0, 0, one));
    send_points(pts(-one, 0, one, 0, 0, one));
    send_points(pts(0, 0, 4 * one, 0, 0, 3 * one));
    send_points(pts(mx, mx, mn, mn, mx, mn));
    send_points(pts(mn, mn, mx, mn, mn, mx));
    send_points(pts(mx, 0, mn, 0, 0, mx));
    send_points(pts(mn, mn, mn, mn, mn, mn));
    send_points(pts(mx, mx, mx, mx, mx, mx));
    send_points(pts(0, 0, 1, 0, 0, 1));
    send_points(pts(0, 0, 1, 0, 2, 1));
    send_points(pts(0, 0, mx, 1, mn, 0));
    send_points(pts(mn, 0, mx, 0, mx, 1));
    send_points(pts(0, mx, 0, mn, 1, 0));
    send_points(pts(-1, -1, 1, -1, 0, 1));
    send_points(pts(mx, mn, mn, mx, 0, 0));
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 2) hold_req <= 1'b1;
      kind = $urandom_range(0, 3);
      p.first_x  = rand_coord(kind);
      p.first_y  = rand_coord(kind);
      p.second_x = rand_coord(kind);
      p.second_y = rand_coord(kind);
      p.third_x  = rand_coord(kind);
      p.third_y  = rand_coord(kind);
      case ($urandom_range(0, 9))
        0: begin  // collinear: third point on the line through the first two
          k = $urandom_range(0, 6) - 3;
          p.first_x  = rand_coord(2);
          p.first_y  = rand_coord(2);
          p.second_x = rand_coord(2);
          p.second_y = rand_coord(2);
          p.third_x  = p.first_x + k * (p.second_x - p.first_x);
          p.third_y  = p.first_y + k * (p.second_y - p.first_y);
        end
        1: begin  // two coincident points
          p.second_x = p.first_x;
          p.second_y = p.first_y;
        end
        2: p.third_y = p.second_y + 1;  // third point one unit above the second point's y
        default: ;
      endcase
      send_points(p);
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
